### rtl/l4fx_pkg.sv
// Shared types and constants for the IPv4/IPv6 L4 header fact extractor.
// No dependencies.
package l4fx_pkg;

    localparam int MAX_EXT_HEADERS = 8;
    localparam int MAX_PACKET_BYTES = 65536;
    localparam int POS_W = $clog2(MAX_PACKET_BYTES);
    localparam int START_W = POS_W + 1;
    localparam int HOP_W = $clog2(MAX_EXT_HEADERS + 1);
    localparam int NUM_KINDS = 15;
    localparam int NUM_SCALARS = 9;

    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_IPV6 = 16'h86DD;

    localparam logic [7:0] NH_HOP = 8'd0;
    localparam logic [7:0] NH_ICMP = 8'd1;
    localparam logic [7:0] NH_TCP = 8'd6;
    localparam logic [7:0] NH_UDP = 8'd17;
    localparam logic [7:0] NH_ROUTE = 8'd43;
    localparam logic [7:0] NH_FRAG = 8'd44;
    localparam logic [7:0] NH_ICMP6 = 8'd58;
    localparam logic [7:0] NH_DEST = 8'd60;
    localparam logic [7:0] NH_SCTP = 8'd132;
    localparam logic [7:0] NH_UDPLITE = 8'd136;

    localparam logic [3:0] KIND_FAMILY = 4'd0;
    localparam logic [3:0] KIND_PROTO = 4'd5;
    localparam logic [3:0] KIND_STATUS = 4'd14;

    localparam int SF_PROTO = 0;
    localparam int SF_TTL = 1;
    localparam int SF_DSCP = 2;
    localparam int SF_FRAG = 3;
    localparam int SF_SPORT = 4;
    localparam int SF_DPORT = 5;
    localparam int SF_FLAGS = 6;
    localparam int SF_ITYPE = 7;
    localparam int SF_ICODE = 8;

    typedef enum logic [8:0] {
        PH_IDLE  = 9'b000000001,
        PH_NONIP = 9'b000000010,
        PH_V4    = 9'b000000100,
        PH_V6    = 9'b000001000,
        PH_EXT   = 9'b000010000,
        PH_FRAG  = 9'b000100000,
        PH_L4    = 9'b001000000,
        PH_DONE  = 9'b010000000,
        PH_BAD   = 9'b100000000
    } t_phase;

    function automatic logic l4_known(input logic [7:0] p);
        return p == NH_TCP || p == NH_UDP || p == NH_UDPLITE || p == NH_SCTP ||
               p == NH_ICMP || p == NH_ICMP6;
    endfunction

endpackage

### rtl/ip_l4_header_fact_extractor.sv
// Top level of the IPv4/IPv6 L4 header fact extractor: byte parser and fact emitter.
// Depends on l4fx_pkg.
//
// Usage: packet beats enter on the input channel (i_in_valid / o_in_stall), one byte
// per beat, starting at the network header; i_first_byte marks the first beat and
// samples i_ether_type, i_last_byte marks the final beat. Every byte is parsed in the
// cycle it is accepted, so the block takes one beat per cycle. After the last beat
// the present facts leave on the output channel (o_out_valid / i_out_stall) in kind
// order, one per cycle, closed by a status fact with o_last_fact high; accepting that
// beat registers the pending set, and the first fact then loads the output register.
// A packet yields between 1 and 13 facts. While facts of the previous packet are still
// queued, a beat carrying i_first_byte is held off with o_in_stall; other beats keep
// flowing, so the only pause comes when a new packet starts before the emitter has
// drained, which the fact count sets. A stall on the output holds the current fact in
// the output register and pauses the emitter. Reset is synchronous, active low, and
// leaves the block idle with no facts pending; it waits for a first beat.
module ip_l4_header_fact_extractor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_packet_byte,
    input  logic        i_first_byte,
    input  logic        i_last_byte,
    input  logic [15:0] i_ether_type,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_fact_kind,
    output logic [63:0] o_fact_value,
    output logic        o_last_fact
);
    import l4fx_pkg::*;

    logic [POS_W-1:0]   r_bp, n_bp;
    t_phase             r_phase, n_phase;
    logic [START_W-1:0] r_hs, n_hs;
    logic [7:0]         r_nh, n_nh;
    logic [HOP_W-1:0]   r_hop, n_hop;
    logic [15:0]        r_et, n_et;
    logic [63:0]        r_aw [4];
    logic [63:0]        n_aw [4];
    logic [15:0]        r_sf [NUM_SCALARS];
    logic [15:0]        n_sf [NUM_SCALARS];
    logic [13:0]        r_mask, n_mask;
    logic [7:0]         r_head, n_head;
    logic [15:0]        r_frag, n_frag;
    logic [NUM_KINDS-1:0] r_pend;
    logic               r_bad;
    logic               n_bad;
    logic               r_out_valid;
    logic [3:0]         r_kind;
    logic [63:0]        r_value;
    logic               r_last;

    logic               in_acc;
    logic               do_parse;
    logic               emits;
    logic [POS_W-1:0]   pos;
    logic [START_W-1:0] rel;
    logic               rt_go;
    logic [7:0]         rt_nh;
    logic [START_W-1:0] rt_start;
    logic               l4_go;
    logic [7:0]         l4_nh;
    logic [START_W-1:0] l4_start;
    logic [1:0]         aw_idx;
    logic               out_adv;
    logic [3:0]         sel;
    logic [63:0]        sel_value;

    assign o_in_stall = (|r_pend) && i_first_byte;
    assign in_acc = i_in_valid && !o_in_stall;
    assign out_adv = !r_out_valid || !i_out_stall;

    always_comb begin
        n_bp = r_bp;
        n_phase = r_phase;
        n_hs = r_hs;
        n_nh = r_nh;
        n_hop = r_hop;
        n_et = r_et;
        n_aw = r_aw;
        n_sf = r_sf;
        n_mask = r_mask;
        n_head = r_head;
        n_frag = r_frag;
        do_parse = 1'b1;
        emits = 1'b0;
        rt_go = 1'b0;
        rt_nh = '0;
        rt_start = '0;
        l4_go = 1'b0;
        l4_nh = '0;
        l4_start = '0;
        rel = '0;
        pos = '0;
        aw_idx = '0;
        n_bad = 1'b0;

        if (i_first_byte) begin
            n_bp = '0;
            n_hs = '0;
            n_nh = '0;
            n_hop = '0;
            n_et = i_ether_type;
            for (int i = 0; i < 4; i++) begin
                n_aw[i] = '0;
            end
            for (int i = 0; i < NUM_SCALARS; i++) begin
                n_sf[i] = '0;
            end
            n_mask = '0;
            n_head = '0;
            n_frag = '0;
            n_phase = (i_ether_type == ETH_IPV4) ? PH_V4 :
                      (i_ether_type == ETH_IPV6) ? PH_V6 : PH_NONIP;
        end else if (r_phase == PH_IDLE) begin
            do_parse = 1'b0;
        end else if (r_bp == POS_W'(MAX_PACKET_BYTES - 1)) begin
            if (r_phase == PH_EXT || r_phase == PH_FRAG || r_phase == PH_L4) begin
                n_phase = PH_DONE;
            end
            do_parse = 1'b0;
        end else begin
            n_bp = r_bp + POS_W'(1);
        end
        emits = i_last_byte && (i_first_byte || r_phase != PH_IDLE);

        pos = n_bp;
        rel = START_W'(pos) - n_hs;
        aw_idx = 2'((pos - POS_W'(8)) >> 3);

        if (do_parse) begin
            case (n_phase)
                PH_V4: begin
                    if (pos == 0) n_head = i_packet_byte;
                    else if (pos == 1) n_sf[SF_DSCP] = {10'd0, i_packet_byte[7:2]};
                    else if (pos == 6) n_frag = {i_packet_byte, 8'd0};
                    else if (pos == 7) n_frag = {n_frag[15:8], i_packet_byte};
                    else if (pos == 8) n_sf[SF_TTL] = {8'd0, i_packet_byte};
                    else if (pos == 9) n_sf[SF_PROTO] = {8'd0, i_packet_byte};
                    else if (pos >= 12 && pos <= 15) n_aw[1] = {n_aw[1][55:0], i_packet_byte};
                    else if (pos >= 16 && pos <= 19) n_aw[3] = {n_aw[3][55:0], i_packet_byte};
                    if (pos == 19) begin
                        if (n_head[7:4] != 4'd4 || n_head[3:0] < 4'd5) begin
                            n_phase = PH_BAD;
                        end else begin
                            n_mask[8:0] = 9'h1ff;
                            n_sf[SF_FRAG] = {15'd0, n_frag[13:0] != 14'd0};
                            if (n_frag[12:0] == 13'd0) begin
                                l4_go = 1'b1;
                                l4_nh = n_sf[SF_PROTO][7:0];
                                l4_start = START_W'({n_head[3:0], 2'b00});
                            end else begin
                                n_phase = PH_DONE;
                            end
                        end
                    end
                end
                PH_V6: begin
                    if (pos == 0) n_head = i_packet_byte;
                    else if (pos == 1) n_sf[SF_DSCP] = {10'd0, n_head[3:0], i_packet_byte[7:6]};
                    else if (pos == 6) n_nh = i_packet_byte;
                    else if (pos == 7) n_sf[SF_TTL] = {8'd0, i_packet_byte};
                    else if (pos >= 8 && pos <= 39) begin
                        n_aw[aw_idx] = {n_aw[aw_idx][55:0], i_packet_byte};
                    end
                    if (pos == 39) begin
                        if (n_head[7:4] != 4'd6) begin
                            n_phase = PH_BAD;
                        end else begin
                            n_mask[4:0] = 5'h1f;
                            n_mask[6] = 1'b1;
                            n_mask[7] = 1'b1;
                            n_mask[8] = 1'b1;
                            n_sf[SF_FRAG] = '0;
                            rt_go = 1'b1;
                            rt_nh = n_nh;
                            rt_start = START_W'(40);
                        end
                    end
                end
                PH_EXT: begin
                    if (START_W'(pos) >= n_hs) begin
                        if (rel == 0) n_nh = i_packet_byte;
                        else if (rel == 1) begin
                            rt_go = 1'b1;
                            rt_nh = n_nh;
                            rt_start = n_hs + START_W'({({1'b0, i_packet_byte} + 9'd1), 3'b000});
                        end
                    end
                end
                PH_FRAG: begin
                    if (START_W'(pos) >= n_hs) begin
                        if (rel == 0) n_nh = i_packet_byte;
                        else if (rel == 2) n_frag = {i_packet_byte, 8'd0};
                        else if (rel == 3) n_frag = {n_frag[15:8], i_packet_byte};
                        else if (rel == 7) begin
                            n_sf[SF_FRAG] = 16'd1;
                            n_mask[8] = 1'b1;
                            if ((n_frag & 16'hfff8) != 16'd0) begin
                                n_phase = PH_DONE;
                            end else begin
                                rt_go = 1'b1;
                                rt_nh = n_nh;
                                rt_start = n_hs + START_W'(8);
                            end
                        end
                    end
                end
                PH_L4: begin
                    if (START_W'(pos) >= n_hs) begin
                        if (n_nh == NH_ICMP || n_nh == NH_ICMP6) begin
                            if (rel == 0) n_sf[SF_ITYPE] = {8'd0, i_packet_byte};
                            if (rel == 1) n_sf[SF_ICODE] = {8'd0, i_packet_byte};
                            if (rel == 7) begin
                                n_mask[12] = 1'b1;
                                n_mask[13] = 1'b1;
                                n_phase = PH_DONE;
                            end
                        end else begin
                            if (rel < 2) n_sf[SF_SPORT] = {n_sf[SF_SPORT][7:0], i_packet_byte};
                            else if (rel < 4) n_sf[SF_DPORT] = {n_sf[SF_DPORT][7:0], i_packet_byte};
                            if (n_nh == NH_TCP && rel == 13) n_sf[SF_FLAGS] = {8'd0, i_packet_byte};
                            if ((n_nh == NH_TCP && rel == 19) ||
                                ((n_nh == NH_UDP || n_nh == NH_UDPLITE) && rel == 7) ||
                                (n_nh == NH_SCTP && rel == 11)) begin
                                n_mask[9] = 1'b1;
                                n_mask[10] = 1'b1;
                                if (n_nh == NH_TCP) n_mask[11] = 1'b1;
                                n_phase = PH_DONE;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        if (rt_go) begin
            if (n_hop >= HOP_W'(MAX_EXT_HEADERS)) begin
                n_phase = PH_DONE;
            end else begin
                n_hop = n_hop + HOP_W'(1);
                n_nh = rt_nh;
                n_hs = rt_start;
                if (rt_nh == NH_HOP || rt_nh == NH_ROUTE || rt_nh == NH_DEST) begin
                    n_phase = PH_EXT;
                end else if (rt_nh == NH_FRAG) begin
                    n_phase = PH_FRAG;
                end else begin
                    n_sf[SF_PROTO] = {8'd0, rt_nh};
                    n_mask[5] = 1'b1;
                    l4_go = 1'b1;
                    l4_nh = rt_nh;
                    l4_start = rt_start;
                end
            end
        end
        if (l4_go) begin
            n_nh = l4_nh;
            n_hs = l4_start;
            n_phase = l4_known(l4_nh) ? PH_L4 : PH_DONE;
        end

        if (emits) begin
            n_bad = n_phase == PH_V4 || n_phase == PH_V6 || n_phase == PH_BAD;
            n_phase = PH_IDLE;
        end
    end

    always_comb begin
        sel = KIND_STATUS;
        for (int k = NUM_KINDS - 1; k >= 0; k--) begin
            if (r_pend[k]) sel = 4'(k);
        end
        if (sel == KIND_FAMILY) begin
            sel_value = (r_et == ETH_IPV4) ? 64'd4 : 64'd6;
        end else if (sel < KIND_PROTO) begin
            sel_value = r_aw[2'(sel - 4'd1)];
        end else if (sel < KIND_STATUS) begin
            sel_value = {48'd0, r_sf[4'(sel - KIND_PROTO)]};
        end else begin
            sel_value = {63'd0, r_bad};
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_hs <= n_hs;
            r_nh <= n_nh;
            r_et <= n_et;
            r_aw <= n_aw;
            r_sf <= n_sf;
            r_head <= n_head;
            r_frag <= n_frag;
        end
        if (out_adv && (|r_pend)) begin
            r_kind <= sel;
            r_value <= sel_value;
            r_last <= sel == KIND_STATUS;
        end
        if (!i_rst_n) begin
            r_bp <= '0;
            r_phase <= PH_IDLE;
            r_hop <= '0;
            r_mask <= '0;
            r_pend <= '0;
            r_bad <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_bp <= n_bp;
                r_phase <= n_phase;
                r_hop <= n_hop;
                r_mask <= n_mask;
            end
            if (out_adv) begin
                r_out_valid <= |r_pend;
            end
            if (in_acc && emits) begin
                r_pend <= {1'b1, n_mask};
                r_bad <= n_bad;
            end else if (out_adv && (|r_pend)) begin
                r_pend[sel] <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_fact_kind = r_kind;
    assign o_fact_value = r_value;
    assign o_last_fact = r_last;

    a_last_is_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_last) |-> (r_kind == KIND_STATUS))
        else $error("closing fact is not a status fact");

    a_pend_has_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|r_pend) |-> r_pend[KIND_STATUS])
        else $error("pending facts without a status fact");

    a_hop_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hop <= HOP_W'(MAX_EXT_HEADERS))
        else $error("extension header count out of range");

endmodule

### sim/testbench.sv
// Self-checking testbench for ip_l4_header_fact_extractor: builds IPv4, IPv6 and noise packets,
// predicts the emitted facts per beat and compares them with the output channel.
// Depends on l4fx_pkg and the extractor RTL.
`timescale 1ns / 100ps

module testbench;
    import l4fx_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [3:0]  kind;
        logic [63:0] value;
        logic        last;
    } t_fact;

    typedef enum int {SH_V4, SH_V4_FRAG, SH_V4_BAD, SH_V6, SH_V6_FRAG, SH_V6_DEEP, SH_RAW} t_shape;

    typedef struct {
        logic [15:0] et;
        t_shape      shape;
        logic [7:0]  proto;
        int          size;
        int          status;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_packet_byte = 8'd0;
    logic        i_first_byte = 1'b0;
    logic        i_last_byte = 1'b0;
    logic [15:0] i_ether_type = 16'd0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [3:0]  o_fact_kind;
    logic [63:0] o_fact_value;
    logic        o_last_fact;

    ip_l4_header_fact_extractor dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Predicted header state.
    int          hp_pos;
    t_phase      hp_phase = PH_IDLE;
    int          hp_start;
    logic [7:0]  hp_nh;
    int          hp_hops;
    logic [15:0] hp_et;
    logic [63:0] hp_addr [4];
    logic [15:0] hp_scalar [NUM_SCALARS];
    logic [14:0] hp_mask;
    logic [7:0]  hp_head;
    logic [15:0] hp_frag;

    t_fact       facts_due [$];
    int          facts_pushed = 0;
    logic [7:0]  pkt [$];
    t_fact       want;
    int          errors = 0;
    int          cycles = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;

    function automatic void mark_fact(input int kind);
        hp_mask[kind] = 1'b1;
    endfunction

    function automatic void store_scalar(input int slot, input logic [15:0] v);
        hp_scalar[slot] = v;
        mark_fact(slot + 5);
    endfunction

    function automatic void enter_l4(input logic [7:0] proto, input int start);
        hp_nh = proto;
        hp_start = start;
        hp_phase = (proto == NH_TCP || proto == NH_UDP || proto == NH_UDPLITE ||
                    proto == NH_SCTP || proto == NH_ICMP || proto == NH_ICMP6) ? PH_L4 : PH_DONE;
    endfunction

    function automatic void walk_next_header(input logic [7:0] nh, input int start);
        if (hp_hops >= MAX_EXT_HEADERS) begin
            hp_phase = PH_DONE;
            return;
        end
        hp_hops++;
        hp_nh = nh;
        hp_start = start;
        if (nh == NH_HOP || nh == NH_ROUTE || nh == NH_DEST) begin
            hp_phase = PH_EXT;
        end else if (nh == NH_FRAG) begin
            hp_phase = PH_FRAG;
        end else begin
            store_scalar(SF_PROTO, {8'd0, nh});
            enter_l4(nh, start);
        end
    endfunction

    function automatic void parse_l4(input int rel, input logic [7:0] b);
        logic [7:0] p;
        p = hp_nh;
        if (p == NH_ICMP || p == NH_ICMP6) begin
            if (rel == 0) hp_scalar[SF_ITYPE] = {8'd0, b};
            if (rel == 1) hp_scalar[SF_ICODE] = {8'd0, b};
            if (rel == 7) begin
                mark_fact(SF_ITYPE + 5);
                mark_fact(SF_ICODE + 5);
                hp_phase = PH_DONE;
            end
            return;
        end
        if (rel < 2) hp_scalar[SF_SPORT] = {hp_scalar[SF_SPORT][7:0], b};
        else if (rel < 4) hp_scalar[SF_DPORT] = {hp_scalar[SF_DPORT][7:0], b};
        if (p == NH_TCP && rel == 13) hp_scalar[SF_FLAGS] = {8'd0, b};
        if ((p == NH_TCP && rel == 19) || ((p == NH_UDP || p == NH_UDPLITE) && rel == 7) ||
            (p == NH_SCTP && rel == 11)) begin
            mark_fact(SF_SPORT + 5);
            mark_fact(SF_DPORT + 5);
            if (p == NH_TCP) mark_fact(SF_FLAGS + 5);
            hp_phase = PH_DONE;
        end
    endfunction

    function automatic void parse_v4(input int p, input logic [7:0] b);
        if (p == 0) hp_head = b;
        else if (p == 1) hp_scalar[SF_DSCP] = {10'd0, b[7:2]};
        else if (p == 6) hp_frag = {b, 8'd0};
        else if (p == 7) hp_frag[7:0] = b;
        else if (p == 8) hp_scalar[SF_TTL] = {8'd0, b};
        else if (p == 9) hp_scalar[SF_PROTO] = {8'd0, b};
        else if (p >= 12 && p <= 15) hp_addr[1] = {hp_addr[1][55:0], b};
        else if (p >= 16 && p <= 19) hp_addr[3] = {hp_addr[3][55:0], b};
        if (p != 19) return;
        if (hp_head[7:4] != 4'd4 || hp_head[3:0] < 4'd5) begin
            hp_phase = PH_BAD;
            return;
        end
        hp_mask[4:0] = 5'h1f;
        mark_fact(SF_PROTO + 5);
        mark_fact(SF_TTL + 5);
        mark_fact(SF_DSCP + 5);
        store_scalar(SF_FRAG, {15'd0, hp_frag[13:0] != 14'd0});
        if (hp_frag[12:0] == 13'd0) enter_l4(hp_scalar[SF_PROTO][7:0], hp_head[3:0] * 4);
        else hp_phase = PH_DONE;
    endfunction

    function automatic void parse_v6(input int p, input logic [7:0] b);
        logic [7:0] tc;
        if (p == 0) begin
            hp_head = b;
        end else if (p == 1) begin
            tc = {hp_head[3:0], b[7:4]};
            hp_scalar[SF_DSCP] = {10'd0, tc[7:2]};
        end else if (p == 6) begin
            hp_nh = b;
        end else if (p == 7) begin
            hp_scalar[SF_TTL] = {8'd0, b};
        end else if (p >= 8 && p <= 39) begin
            hp_addr[(p - 8) >> 3] = {hp_addr[(p - 8) >> 3][55:0], b};
        end
        if (p != 39) return;
        if (hp_head[7:4] != 4'd6) begin
            hp_phase = PH_BAD;
            return;
        end
        hp_mask[4:0] = 5'h1f;
        mark_fact(SF_TTL + 5);
        mark_fact(SF_DSCP + 5);
        store_scalar(SF_FRAG, 16'd0);
        walk_next_header(hp_nh, 40);
    endfunction

    function automatic void parse_header_byte(input logic [7:0] b);
        int rel;
        if (hp_phase == PH_V4) begin
            parse_v4(hp_pos, b);
            return;
        end
        if (hp_phase == PH_V6) begin
            parse_v6(hp_pos, b);
            return;
        end
        if (hp_phase != PH_EXT && hp_phase != PH_FRAG && hp_phase != PH_L4) return;
        if (hp_pos < hp_start) return;
        rel = hp_pos - hp_start;
        if (hp_phase == PH_L4) begin
            parse_l4(rel, b);
        end else if (hp_phase == PH_EXT) begin
            if (rel == 0) hp_nh = b;
            else if (rel == 1) walk_next_header(hp_nh, hp_start + (int'(b) + 1) * 8);
        end else begin
            if (rel == 0) hp_nh = b;
            else if (rel == 2) hp_frag = {b, 8'd0};
            else if (rel == 3) hp_frag[7:0] = b;
            else if (rel == 7) begin
                store_scalar(SF_FRAG, 16'd1);
                if ((hp_frag & 16'hfff8) != 16'd0) hp_phase = PH_DONE;
                else walk_next_header(hp_nh, hp_start + 8);
            end
        end
    endfunction

    function automatic void predict_facts(input logic [7:0] b, input logic first,
                                          input logic last, input logic [15:0] et);
        logic  go;
        t_fact f;
        go = 1'b1;
        if (first) begin
            hp_pos = 0;
            hp_start = 0;
            hp_nh = 8'd0;
            hp_hops = 0;
            for (int i = 0; i < 4; i++) hp_addr[i] = 64'd0;
            for (int i = 0; i < NUM_SCALARS; i++) hp_scalar[i] = 16'd0;
            hp_mask = 15'd0;
            hp_head = 8'd0;
            hp_frag = 16'd0;
            hp_et = et;
            hp_phase = (et == ETH_IPV4) ? PH_V4 : ((et == ETH_IPV6) ? PH_V6 : PH_NONIP);
        end else begin
            if (hp_phase == PH_IDLE) return;
            if (hp_pos >= MAX_PACKET_BYTES - 1) begin
                if (hp_phase == PH_EXT || hp_phase == PH_FRAG || hp_phase == PH_L4)
                    hp_phase = PH_DONE;
                go = 1'b0;
            end else begin
                hp_pos++;
            end
        end
        if (go) parse_header_byte(b);
        if (!last) return;
        for (int k = 0; k < KIND_STATUS; k++) begin
            if (hp_mask[k]) begin
                f.kind = k[3:0];
                if (k == KIND_FAMILY) f.value = (hp_et == ETH_IPV4) ? 64'd4 : 64'd6;
                else if (k <= 4) f.value = hp_addr[k - 1];
                else f.value = {48'd0, hp_scalar[k - 5]};
                f.last = 1'b0;
                facts_due.push_back(f);
                facts_pushed++;
            end
        end
        f.kind = KIND_STATUS;
        f.value = (hp_phase == PH_V4 || hp_phase == PH_V6 || hp_phase == PH_BAD) ? 64'd1 : 64'd0;
        f.last = 1'b1;
        facts_due.push_back(f);
        facts_pushed++;
        hp_phase = PH_IDLE;
    endfunction

    task automatic send_beat(input logic [7:0] b, input logic first, input logic last,
                             input logic [15:0] et);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_packet_byte <= b;
        i_first_byte <= first;
        i_last_byte <= last;
        i_ether_type <= et;
        do @(posedge i_clk); while (o_in_stall);
        predict_facts(b, first, last, et);
    endtask

    task automatic send_packet(input logic [15:0] et, input int count, input logic close);
        for (int i = 0; i < count; i++)
            send_beat(pkt[i], i == 0, close && i == count - 1, i == 0 ? et : 16'($urandom));
    endtask

    function automatic void add_bytes(input int n);
        for (int i = 0; i < n; i++) pkt.push_back(8'($urandom));
    endfunction

    function automatic void add_l4(input logic [7:0] proto);
        if (proto == NH_TCP) add_bytes(20);
        else if (proto == NH_SCTP) add_bytes(12);
        else if (proto == NH_UDP || proto == NH_UDPLITE || proto == NH_ICMP ||
                 proto == NH_ICMP6) add_bytes(8);
        else add_bytes(4);
        add_bytes($urandom_range(6));
    endfunction

    function automatic void build_packet(input t_shape sh, input logic [7:0] proto,
                                         input int size);
        logic [3:0] ihl;
        logic [7:0] chain [$];
        logic [7:0] nxt;
        int         n;
        pkt.delete();
        if (sh == SH_V4 || sh == SH_V4_FRAG || sh == SH_V4_BAD) begin
            ihl = ($urandom_range(3) == 0) ? 4'($urandom_range(15, 6)) : 4'd5;
            pkt.push_back({4'd4, ihl});
            if (sh == SH_V4_BAD) begin
                if ($urandom_range(1)) pkt[0][7:4] = 4'($urandom_range(15, 5));
                else pkt[0][3:0] = 4'($urandom_range(4));
            end
            add_bytes(5);
            if (sh == SH_V4_FRAG) begin
                pkt.push_back(8'($urandom));
                pkt.push_back(8'($urandom) | 8'h01);
            end else begin
                pkt.push_back(8'($urandom) & 8'he0);
                pkt.push_back(8'h00);
            end
            add_bytes(1);
            pkt.push_back(proto);
            add_bytes(ihl * 4 - 10);
            add_l4(proto);
        end else if (sh == SH_RAW) begin
            add_bytes($urandom_range(60, 1));
        end else begin
            n = (sh == SH_V6_DEEP) ? 9 : $urandom_range(3);
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(3))
                    0: chain.push_back(NH_HOP);
                    1: chain.push_back(NH_ROUTE);
                    2: chain.push_back(NH_DEST);
                    default: chain.push_back(NH_FRAG);
                endcase
            end
            if (sh == SH_V6_FRAG) chain.push_back(NH_FRAG);
            pkt.push_back({4'd6, 4'($urandom)});
            add_bytes(5);
            pkt.push_back(chain.size() > 0 ? chain[0] : proto);
            add_bytes(33);
            for (int i = 0; i < chain.size(); i++) begin
                nxt = (i + 1 < chain.size()) ? chain[i + 1] : proto;
                pkt.push_back(nxt);
                if (chain[i] == NH_FRAG) begin
                    add_bytes(1);
                    if (sh == SH_V6_FRAG && i == chain.size() - 1) begin
                        pkt.push_back(8'($urandom_range(255, 1)));
                        add_bytes(1);
                    end else begin
                        pkt.push_back(8'h00);
                        pkt.push_back(8'($urandom) & 8'h07);
                    end
                    add_bytes(4);
                end else begin
                    pkt.push_back(8'($urandom_range(2)));
                    add_bytes((pkt[pkt.size() - 1] + 1) * 8 - 2);
                end
            end
            add_l4(proto);
        end
        if (size > 0) begin
            while (pkt.size() > size) void'(pkt.pop_back());
            if (pkt.size() < size) add_bytes(size - pkt.size());
        end
    endfunction

    function automatic logic [7:0] pick_proto();
        case ($urandom_range(6))
            0: return NH_ICMP;
            1: return NH_TCP;
            2: return NH_UDP;
            3: return NH_ICMP6;
            4: return NH_SCTP;
            5: return NH_UDPLITE;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_shape pick_ip_shape();
        case ($urandom_range(9))
            0: return SH_V4_FRAG;
            1: return SH_V4_BAD;
            2: return SH_V6_FRAG;
            3: return SH_V6_DEEP;
            4, 5, 6: return SH_V4;
            default: return SH_V6;
        endcase
    endfunction

    function automatic logic [15:0] ether_of(input t_shape sh);
        return (sh == SH_V4 || sh == SH_V4_FRAG || sh == SH_V4_BAD) ? ETH_IPV4 : ETH_IPV6;
    endfunction

    task automatic send_random_packet();
        int     r;
        t_shape sh;
        r = $urandom_range(99);
        sh = pick_ip_shape();
        if (r < 60) begin
            build_packet(sh, pick_proto(), 0);
            send_packet(ether_of(sh), pkt.size(), 1'b1);
        end else if (r < 70) begin
            build_packet(sh, pick_proto(), $urandom_range(70, 1));
            send_packet(ether_of(sh), pkt.size(), 1'b1);
        end else if (r < 78) begin
            build_packet(SH_RAW, 8'd0, 0);
            send_packet(16'($urandom), pkt.size(), 1'b1);
        end else if (r < 85) begin
            build_packet(SH_RAW, 8'd0, $urandom_range(50, 1));
            send_packet($urandom_range(1) ? ETH_IPV4 : ETH_IPV6, pkt.size(), 1'b1);
        end else if (r < 92) begin
            repeat ($urandom_range(3, 1))
                send_beat(8'($urandom), 1'b0, 1'($urandom), 16'($urandom));
        end else begin
            build_packet(sh, pick_proto(), 0);
            send_packet(ether_of(sh), $urandom_range(pkt.size(), 1), 1'b0);
            sh = pick_ip_shape();
            build_packet(sh, pick_proto(), 0);
            send_packet(ether_of(sh), pkt.size(), 1'b1);
        end
    endtask

    task automatic drain_facts();
        i_in_valid <= 1'b0;
        while (facts_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (facts_due.size() == 0) begin
                $error("unexpected fact: kind %0d value %h", o_fact_kind, o_fact_value);
                errors++;
            end else begin
                want = facts_due.pop_front();
                if (o_fact_kind !== want.kind) begin
                    $error("fact_kind: expected %0d, got %0d", want.kind, o_fact_kind);
                    errors++;
                end
                if (o_fact_value !== want.value) begin
                    $error("fact_value: expected %h, got %h", want.value, o_fact_value);
                    errors++;
                end
                if (o_last_fact !== want.last) begin
                    $error("last_fact: expected %0d, got %0d", want.last, o_last_fact);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL ip_l4_header_fact_extractor");
            $finish;
        end
    end

    t_row directed [] = '{
        '{ETH_IPV4, SH_V4, NH_TCP, 0, -1},
        '{ETH_IPV4, SH_V4, NH_UDP, 0, -1},
        '{ETH_IPV4, SH_V4, NH_UDPLITE, 0, -1},
        '{ETH_IPV4, SH_V4, NH_SCTP, 0, -1},
        '{ETH_IPV4, SH_V4, NH_ICMP, 0, -1},
        '{ETH_IPV4, SH_V4, 8'hff, 0, -1},
        '{ETH_IPV4, SH_V4_FRAG, NH_TCP, 0, -1},
        '{ETH_IPV4, SH_V4_BAD, NH_UDP, 0, 1},
        '{ETH_IPV4, SH_V4, NH_TCP, 1, 1},
        '{ETH_IPV4, SH_V4, NH_TCP, 19, 1},
        '{ETH_IPV4, SH_V4, NH_TCP, 30, -1},
        '{ETH_IPV6, SH_V6, NH_ICMP6, 0, -1},
        '{ETH_IPV6, SH_V6, NH_TCP, 0, -1},
        '{ETH_IPV6, SH_V6, 8'h00, 0, -1},
        '{ETH_IPV6, SH_V6_FRAG, NH_UDP, 0, -1},
        '{ETH_IPV6, SH_V6_DEEP, NH_TCP, 0, -1},
        '{ETH_IPV6, SH_V6, NH_UDP, 30, 1},
        '{16'h0000, SH_RAW, 8'd0, 0, 0},
        '{16'hffff, SH_RAW, 8'd0, 0, 0},
        '{16'h86dc, SH_RAW, 8'd0, 1, 0}
    };

    initial begin
        int    added;
        t_fact typed;
        int    idle_sets [4][2] = '{'{0, 0}, '{75, 0}, '{0, 75}, '{35, 35}};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            build_packet(directed[i].shape, directed[i].proto, directed[i].size);
            added = facts_pushed;
            send_packet(directed[i].et, pkt.size(), 1'b1);
            if (directed[i].status >= 0) begin
                repeat (facts_pushed - added) void'(facts_due.pop_back());
                typed.kind = KIND_STATUS;
                typed.value = 64'(directed[i].status);
                typed.last = 1'b1;
                facts_due.push_back(typed);
            end
        end
        send_beat(8'hff, 1'b0, 1'b1, 16'hffff);
        build_packet(SH_V4, NH_TCP, 0);
        send_packet(ETH_IPV4, 12, 1'b0);
        build_packet(SH_V6, NH_UDP, 0);
        send_packet(ETH_IPV6, pkt.size(), 1'b1);
        drain_facts();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_sets[ph][0];
            stall_pct = idle_sets[ph][1];
            for (int n = 0; n < 3; n++) begin
                send_random_packet();
            end
            drain_facts();
        end

        stall_pct = 0;
        if (errors == 0 && facts_due.size() == 0) begin
            $display("PASS ip_l4_header_fact_extractor");
        end else begin
            $display("FAIL ip_l4_header_fact_extractor");
        end
        $finish;
    end

endmodule
